// ----- rtl/core/bdq_pkg.sv -----
// Shared types and constants for the bounded deque with index search.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    localparam int REQ_W       = 3;
    localparam int IDX_W       = 4;
    localparam int HIN_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    localparam int S_REQ_LSB   = 0;
    localparam int S_IDX_LSB   = S_REQ_LSB + REQ_W;
    localparam int S_HND_LSB   = S_IDX_LSB + IDX_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ_NTH   = 3'd4,
        REQ_WRITE_NTH  = 3'd5,
        REQ_FIND       = 3'd6,
        REQ_CLEAR      = 3'd7
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_NULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef struct packed {
        logic [OCC_W-1:0]    occupancy;
        logic                found;
        logic [HIN_W-1:0]    handle_out;
        status_t             status;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/bounded_deque_with_index_search_core.sv -----
// Top level of the bounded deque of handles with indexed access and search.
`timescale 1ns / 1ps
`default_nettype none

// The block holds up to DEPTH nonzero handles in a ring store and serves one request per
// transfer on the slave side, returning one result transfer on the master side. Pushes,
// writes, clears, finds on an empty deque and requests that fail a check return their
// result in the cycle after acceptance. Pops and reads by index go through the registered
// read port of the store and then the result register. A find scans the held entries from
// the front, one entry per cycle through the shared slot and compare path, and stops at
// the first match or at the last held entry. The block takes a new request only when no
// request is in progress and the result register is empty or being drained in the same cycle.

module bounded_deque_with_index_search_core
    import bdq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int HANDLE_W = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // req_type [2:0], index [6:3], handle [22:7], zero [23]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status [1:0], handle_out [17:2], found [18], occupancy [23:19]
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [2:0] {
        FSM_IDLE = 3'b001,
        FSM_READ = 3'b010,
        FSM_SCAN = 3'b100
    } fsm_t;

    fsm_t                state_reg, state_next;
    logic [AW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;
    logic                m_valid_reg, m_valid_next;
    result_t             m_data_reg, m_data_next;

    req_t                in_req;
    logic [IDX_W-1:0]    in_idx;
    logic [HANDLE_W-1:0] in_h;
    logic                out_free;
    logic                accept;
    logic                full;
    logic                empty;
    logic                in_null;
    logic                in_range;
    logic [AW-1:0]       pos_sel;
    logic [AW-1:0]       slot;
    logic [AW-1:0]       front_inc;
    logic [HANDLE_W-1:0] rdata;
    logic                match;
    logic                last;
    logic                scan_done;
    mem_ctl_t            mem_ctl;
    logic                res_load;
    result_t             res;

    assign in_req    = req_t'(s_tdata[S_REQ_LSB +: REQ_W]);
    assign in_idx    = s_tdata[S_IDX_LSB +: IDX_W];
    assign in_h      = HANDLE_W'(s_tdata[S_HND_LSB +: HIN_W]);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == FSM_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign in_null   = (in_h == '0);
    assign in_range  = (CMPW'(in_idx) < CMPW'(count_reg));
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign match     = (rdata == hnd_reg);
    assign last      = ((CW'(pos_reg) + CW'(1)) == count_reg);
    assign scan_done = match || last;

    always_comb begin
        if (state_reg == FSM_SCAN) begin
            pos_sel = pos_reg + 1'b1;
        end else begin
            case (in_req)
                REQ_PUSH_FRONT: pos_sel = AW'(DEPTH - 1);
                REQ_PUSH_BACK:  pos_sel = AW'(count_reg);
                REQ_POP_BACK:   pos_sel = AW'(count_reg - 1'b1);
                REQ_READ_NTH,
                REQ_WRITE_NTH:  pos_sel = AW'(in_idx);
                default:        pos_sel = '0;
            endcase
        end
    end

    bdq_slot #(
        .DEPTH (DEPTH)
    ) u_slot (
        .base   (front_reg),
        .offset (pos_sel),
        .slot   (slot)
    );

    bdq_store #(
        .DEPTH    (DEPTH),
        .HANDLE_W (HANDLE_W)
    ) u_store (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .addr  (slot),
        .wdata (in_h),
        .rdata (rdata)
    );

    always_comb begin
        state_next = state_reg;
        front_next = front_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        hnd_next   = hnd_reg;
        mem_ctl    = '0;
        res_load   = 1'b0;
        res.status     = STAT_OK;
        res.handle_out = '0;
        res.found      = 1'b0;

        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    res_load = 1'b1;
                    case (in_req)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            if (in_null) begin
                                res.status = STAT_NULL;
                            end else if (full) begin
                                res.status = STAT_FULL;
                            end else begin
                                mem_ctl.wr_en = 1'b1;
                                count_next    = count_reg + 1'b1;
                                if (in_req == REQ_PUSH_FRONT) begin
                                    front_next = slot;
                                end
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (empty) begin
                                res.status = STAT_NULL;
                            end else begin
                                res_load      = 1'b0;
                                mem_ctl.rd_en = 1'b1;
                                count_next    = count_reg - 1'b1;
                                state_next    = FSM_READ;
                                if (in_req == REQ_POP_FRONT) begin
                                    front_next = front_inc;
                                end
                            end
                        end
                        REQ_READ_NTH: begin
                            if (!in_range) begin
                                res.status = STAT_RANGE;
                            end else begin
                                res_load      = 1'b0;
                                mem_ctl.rd_en = 1'b1;
                                state_next    = FSM_READ;
                            end
                        end
                        REQ_WRITE_NTH: begin
                            if (in_null) begin
                                res.status = STAT_NULL;
                            end else if (!in_range) begin
                                res.status = STAT_RANGE;
                            end else begin
                                mem_ctl.wr_en = 1'b1;
                            end
                        end
                        REQ_FIND: begin
                            if (in_null) begin
                                res.status = STAT_NULL;
                            end else if (!empty) begin
                                res_load      = 1'b0;
                                mem_ctl.rd_en = 1'b1;
                                pos_next      = '0;
                                hnd_next      = in_h;
                                state_next    = FSM_SCAN;
                            end
                        end
                        default: begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            FSM_READ: begin
                if (out_free) begin
                    res_load       = 1'b1;
                    res.handle_out = HIN_W'(rdata);
                    state_next     = FSM_IDLE;
                end
            end
            FSM_SCAN: begin
                if (!scan_done) begin
                    mem_ctl.rd_en = 1'b1;
                    pos_next      = pos_reg + 1'b1;
                end else if (out_free) begin
                    res_load   = 1'b1;
                    res.found  = match;
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase

        res.occupancy = OCC_W'(count_next);
    end

    assign m_valid_next = res_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    assign m_data_next  = res_load ? res : m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        hnd_reg    <= hnd_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bdq_store.sv -----
// Ring store of handles with one access port and a registered read.
`timescale 1ns / 1ps
`default_nettype none

module bdq_store
    import bdq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int HANDLE_W = 16,
    localparam int AW      = $clog2(DEPTH)
) (
    input  wire logic                aclk,
    input  wire mem_ctl_t            ctl,
    input  wire logic [AW-1:0]       addr,
    input  wire logic [HANDLE_W-1:0] wdata,
    output logic      [HANDLE_W-1:0] rdata
);

    logic [HANDLE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bdq_slot.sv -----
// Shared slot unit that maps a position from the front to a ring slot.
`timescale 1ns / 1ps
`default_nettype none

module bdq_slot
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic [AW-1:0] base,
    input  wire logic [AW-1:0] offset,
    output logic      [AW-1:0] slot
);

    logic [AW:0] sum;

    always_comb begin
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (AW+1)'(DEPTH)) begin
            slot = AW'(sum - (AW+1)'(DEPTH));
        end else begin
            slot = AW'(sum);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bdq_check.sv -----
// Port-level checker for the bounded deque core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bdq_check
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed while stalled.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid || !s_tready)
        else $error("Accepted transfer left neither a result nor a busy core.");

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != STAT_OK) |-> (m_tdata[18:2] == '0))
        else $error("Failed request returned a handle or a match.");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (DEPTH > 31) || (m_tdata[23:19] <= DEPTH))
        else $error("Occupancy beyond capacity.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");

endmodule

bind bounded_deque_with_index_search_core bdq_check #(
    .DEPTH (DEPTH)
) u_bdq_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
